[rtl/jsesc_pkg.sv]
// Shared types, constants and helper functions for the JSON string escaper.
// No dependencies; imported by every module of the block.

package jsesc_pkg;

	// One raw string byte as it enters the block.
	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	// One escaped output byte or error report.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_end;
		logic       string_end;
		logic       bad_utf8;
	} out_item_t;

	// Work handed from the front to the back.
	typedef enum logic [1:0] {
		CMD_ASCII = 2'd0,
		CMD_SEQ   = 2'd1,
		CMD_ERR   = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t       kind;
		logic [3:0][7:0] bytes;  // ASCII uses entry 0; a sequence uses 0..cnt
		logic [1:0]      cnt;    // held bytes of a sequence, 1..3
		logic            last;
	} cmd_t;

	localparam logic [7:0] CHR_QUOTE     = 8'h22;
	localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
	localparam logic [7:0] CHR_BS        = 8'h08;
	localparam logic [7:0] CHR_FF        = 8'h0C;
	localparam logic [7:0] CHR_LF        = 8'h0A;
	localparam logic [7:0] CHR_CR        = 8'h0D;
	localparam logic [7:0] CHR_TAB       = 8'h09;
	localparam logic [7:0] CHR_DEL       = 8'h7F;
	localparam logic [7:0] CHR_SPACE     = 8'h20;
	localparam logic [7:0] CHR_LOW_B     = 8'h62;
	localparam logic [7:0] CHR_LOW_F     = 8'h66;
	localparam logic [7:0] CHR_LOW_N     = 8'h6E;
	localparam logic [7:0] CHR_LOW_R     = 8'h72;
	localparam logic [7:0] CHR_LOW_T     = 8'h74;
	localparam logic [7:0] CHR_LOW_U     = 8'h75;
	localparam logic [7:0] CHR_ZERO      = 8'h30;
	localparam logic [7:0] CHR_LOW_A     = 8'h61;

	// Index of the final result of each kind of ASCII run.
	localparam logic [2:0] LAST_PLAIN = 3'd0;
	localparam logic [2:0] LAST_SHORT = 3'd1;
	localparam logic [2:0] LAST_UHEX  = 3'd5;

	// Second byte of a two-byte escape, zero when the byte has none.
	function automatic logic [7:0] short_escape(input logic [7:0] b);
		logic [7:0] e;
		unique case (b)
			CHR_QUOTE:     e = CHR_QUOTE;
			CHR_BACKSLASH: e = CHR_BACKSLASH;
			CHR_BS:        e = CHR_LOW_B;
			CHR_FF:        e = CHR_LOW_F;
			CHR_LF:        e = CHR_LOW_N;
			CHR_CR:        e = CHR_LOW_R;
			CHR_TAB:       e = CHR_LOW_T;
			default:       e = 8'h00;
		endcase
		return e;
	endfunction

	// Lower-case hex character of one nibble.
	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		logic [7:0] c;
		if (v < 4'd10) begin
			c = CHR_ZERO + {4'h0, v};
		end else begin
			c = CHR_LOW_A + {4'h0, v} - 8'd10;
		end
		return c;
	endfunction

endpackage

[rtl/jsesc_front.sv]
// Front end: accepts raw bytes, tracks UTF-8 sequences and the drop state,
// and issues one command per byte that causes output. Uses jsesc_pkg.

module jsesc_front
	import jsesc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	input  logic     cmd_full,
	output logic     cmd_push,
	output cmd_t     cmd_data
);

	logic [1:0]      pend_q;
	logic [1:0]      total_q;
	logic            discard_q;
	logic [2:0][7:0] held_q;

	logic [1:0] pend_d;
	logic [1:0] total_d;
	logic       discard_d;
	logic       hold_en;
	logic       accept;
	logic [7:0] b;
	logic       last;
	logic       is_cont;

	assign in_ready = !cmd_full;
	assign accept   = in_valid && in_ready;
	assign b        = in_item.in_byte;
	assign last     = in_item.in_last;
	assign is_cont  = (b[7:6] == 2'b10);

	always_comb begin
		pend_d        = pend_q;
		total_d       = total_q;
		discard_d     = discard_q;
		hold_en       = 1'b0;
		cmd_push      = 1'b0;
		cmd_data.kind = CMD_ERR;
		cmd_data.cnt  = pend_q;
		cmd_data.last = last;
		for (int k = 0; k < 3; k++) begin
			if (2'(k) == pend_q) begin
				cmd_data.bytes[k] = b;
			end else begin
				cmd_data.bytes[k] = held_q[k];
			end
		end
		cmd_data.bytes[3] = b;
		if (accept) begin
			priority if (discard_q) begin
				// drop until the string closes
				if (last) begin
					discard_d = 1'b0;
				end
			end else if (pend_q != 2'd0) begin
				if (!is_cont || (pend_q < total_q && last)) begin
					cmd_push      = 1'b1;
					cmd_data.kind = CMD_ERR;
				end else if (pend_q >= total_q) begin
					cmd_push      = 1'b1;
					cmd_data.kind = CMD_SEQ;
					pend_d        = 2'd0;
					total_d       = 2'd0;
				end else begin
					hold_en = 1'b1;
					pend_d  = pend_q + 2'd1;
				end
			end else if (!b[7]) begin
				cmd_push      = 1'b1;
				cmd_data.kind = CMD_ASCII;
			end else if (!last && (b[7:5] == 3'b110 || b[7:4] == 4'b1110
					|| b[7:3] == 5'b11110)) begin
				hold_en = 1'b1;
				pend_d  = 2'd1;
				priority if (b[7:5] == 3'b110) begin
					total_d = 2'd1;
				end else if (b[7:4] == 4'b1110) begin
					total_d = 2'd2;
				end else begin
					total_d = 2'd3;
				end
			end else begin
				// bad lead byte, or a lead byte that ends the string
				cmd_push      = 1'b1;
				cmd_data.kind = CMD_ERR;
			end
			if (cmd_push && cmd_data.kind == CMD_ERR) begin
				pend_d    = 2'd0;
				total_d   = 2'd0;
				discard_d = !last;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= 2'd0;
			total_q   <= 2'd0;
			discard_q <= 1'b0;
		end else begin
			pend_q    <= pend_d;
			total_q   <= total_d;
			discard_q <= discard_d;
		end
	end

	// pend_q is 0..2 whenever a byte is held
	always_ff @(posedge clk) begin
		if (hold_en) begin
			held_q[pend_q] <= b;
		end
	end

endmodule

[rtl/jsesc_fifo.sv]
// Short command queue between the front and the back.
// Uses jsesc_pkg for the command type.

module jsesc_fifo
	import jsesc_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[rtl/jsesc_back.sv]
// Back end: expands the command at the queue head into output bytes, one
// per cycle while out_ready allows, into a registered output stage. Uses jsesc_pkg.

module jsesc_back
	import jsesc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  cmd_t      head,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	out_item_t  out_q;

	logic       advance;
	logic [2:0] last_idx;
	logic [7:0] ch;
	logic [7:0] esc;
	logic       is_ctrl;
	logic [7:0] b0;

	assign b0      = head.bytes[0];
	assign esc     = short_escape(b0);
	assign is_ctrl = (b0 < CHR_SPACE) || (b0 == CHR_DEL);
	assign advance = head_valid && (!out_valid_q || out_ready);
	assign pop     = advance && (idx_q == last_idx);

	always_comb begin
		last_idx = LAST_PLAIN;
		ch       = 8'h00;
		unique case (head.kind)
			CMD_ASCII: begin
				if (esc != 8'h00) begin
					last_idx = LAST_SHORT;
					ch       = (idx_q == 3'd0) ? CHR_BACKSLASH : esc;
				end else if (is_ctrl) begin
					last_idx = LAST_UHEX;
					unique case (idx_q)
						3'd0:    ch = CHR_BACKSLASH;
						3'd1:    ch = CHR_LOW_U;
						3'd2:    ch = CHR_ZERO;
						3'd3:    ch = CHR_ZERO;
						3'd4:    ch = hex_digit(b0[7:4]);
						default: ch = hex_digit(b0[3:0]);
					endcase
				end else begin
					ch = b0;
				end
			end
			CMD_SEQ: begin
				last_idx = {1'b0, head.cnt};
				ch       = head.bytes[idx_q[1:0]];
			end
			default: begin
				last_idx = LAST_PLAIN;
				ch       = 8'h00;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				idx_q       <= pop ? 3'd0 : idx_q + 3'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.out_byte   <= ch;
			out_q.run_end    <= (idx_q == last_idx);
			out_q.string_end <= head.last;
			out_q.bad_utf8   <= (head.kind == CMD_ERR);
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

[rtl/json_string_escaper_utf8_check.sv]
// Top level of the JSON string escaper with UTF-8 structure check.
// Depends on jsesc_pkg, jsesc_front, jsesc_fifo and jsesc_back.
//
// Usage:
//   Input channel (in_valid/in_ready/in_item) takes one raw string byte per
//   request; in_item.in_last marks the final byte of a string.
//   Output channel (out_valid/out_ready/out_item) delivers escaped bytes.
//   run_end flags the final byte caused by one input byte, string_end
//   repeats that byte's in_last, and bad_utf8 flags the single zero-byte
//   error report of a malformed string, whose remaining bytes are dropped.
// Path: an input request is written into the command queue, then expanded into the registered output stage.
// Throughput: one input byte per cycle for plain ASCII and UTF-8 data while
//   out_ready stays high; the output register emits one byte per cycle, so a
//   two-byte escape, a \u00XX escape and a completed multibyte sequence each
//   emit their bytes one by one. Those runs fill the command queue, and
//   in_ready drops while it is full.
// Reset: arst_n clears the sequence tracker, drop state, queue and output
//   valid; held bytes need no reset.
// Stall: a low out_ready holds the output register; the queue then fills
//   and backpressure reaches the input side after QUEUE_DEPTH commands.

module json_string_escaper_utf8_check
	import jsesc_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	cmd_t cmd_push_data;
	cmd_t cmd_head;
	logic cmd_push;
	logic cmd_full;
	logic cmd_pop;
	logic cmd_head_valid;

	// classify bytes and track open sequences
	jsesc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.cmd_full (cmd_full),
		.cmd_push (cmd_push),
		.cmd_data (cmd_push_data)
	);

	// decouple the front from output stalls
	jsesc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (cmd_push),
		.push_data  (cmd_push_data),
		.full       (cmd_full),
		.pop        (cmd_pop),
		.head_valid (cmd_head_valid),
		.head       (cmd_head)
	);

	// expand each command into output bytes
	jsesc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (cmd_head_valid),
		.head       (cmd_head),
		.pop        (cmd_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item)
	);

endmodule

[sim/tb_json_string_escaper_utf8_check.sv]
// Testbench for json_string_escaper_utf8_check: directed and random strings with
// a self-contained escaping and UTF-8 structure predictor checked on every output byte.
// Depends on jsesc_pkg and the RTL of the block only.

module tb_json_string_escaper_utf8_check;
	timeunit 1ns;
	timeprecision 1ps;
	import jsesc_pkg::*;

	localparam int CLK_HALF       = 5;
	localparam int RESET_CYCLES   = 6;
	localparam int RANDOM_BYTES   = 292;
	localparam int IDLE_PCT       = 26;
	localparam int STEADY_FROM    = 150;
	localparam int STEADY_TO      = 230;
	localparam int MAX_REPORTS    = 10;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 1000;

	// UTF-8 byte classes
	localparam logic [7:0] ASCII_BIT  = 8'h80;
	localparam logic [7:0] TOP2_MASK  = 8'hC0;
	localparam logic [7:0] CONT_TAG   = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_TAG  = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_TAG  = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_TAG  = 8'hF0;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_item_t  in_item   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;

	json_string_escaper_utf8_check DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always #CLK_HALF clk = ~clk;

	// Raw string bytes waiting to be offered, and escaped bytes still owed by the block.
	in_item_t  raw_bytes_q [$];
	out_item_t escaped_q [$];

	// Predictor state: the open multibyte sequence and the drop flag of an aborted string.
	logic [1:0] seq_held = 2'd0;
	logic [7:0] seq_bytes [3];
	logic [1:0] seq_need = 2'd0;
	logic       dropping = 1'b0;

	int random_live   = 0;
	int bytes_in      = 0;
	int strings_in    = 0;
	int results_seen  = 0;
	int error_reports = 0;
	int mismatches    = 0;
	int idle_cycles   = 0;

	// Hold both sides busy through a window of the run so back-to-back traffic is seen.
	wire steady = (bytes_in >= STEADY_FROM) && (bytes_in < STEADY_TO);

	function automatic logic [7:0] nibble_char(input logic [3:0] v);
		if (v < 4'd10) begin
			return CHR_ZERO + v;
		end
		return CHR_LOW_A + (v - 4'd10);
	endfunction

	// Abort the string: clear the sequence, report once, drop the rest unless it ended here.
	task automatic predict_abort(input logic last);
		out_item_t r;
		seq_held = 2'd0;
		seq_need = 2'd0;
		dropping = !last;
		r.out_byte   = 8'h00;
		r.run_end    = 1'b1;
		r.string_end = last;
		r.bad_utf8   = 1'b1;
		escaped_q.push_back(r);
		error_reports++;
	endtask

	// Work out the escaped bytes caused by one accepted string byte.
	task automatic predict_escape(input in_item_t it);
		logic [7:0] run_bytes [6];
		logic [7:0] b;
		logic [7:0] esc;
		out_item_t  r;
		int         n;
		int         k;
		b   = it.in_byte;
		esc = 8'h00;
		n   = 0;
		if (dropping) begin
			if (it.in_last) begin
				dropping = 1'b0;
			end
		end else if (seq_held != 2'd0) begin
			if ((b & TOP2_MASK) != CONT_TAG) begin
				predict_abort(it.in_last);
			end else if (seq_held >= seq_need) begin
				// release the whole sequence together with its final byte
				for (k = 0; k < seq_held; k++) begin
					run_bytes[n] = seq_bytes[k];
					n++;
				end
				run_bytes[n] = b;
				n++;
				seq_held = 2'd0;
				seq_need = 2'd0;
			end else if (it.in_last) begin
				predict_abort(1'b1);
			end else begin
				seq_bytes[seq_held] = b;
				seq_held++;
			end
		end else if ((b & ASCII_BIT) == 8'h00) begin
			case (b)
				CHR_QUOTE:     esc = CHR_QUOTE;
				CHR_BACKSLASH: esc = CHR_BACKSLASH;
				CHR_BS:        esc = CHR_LOW_B;
				CHR_FF:        esc = CHR_LOW_F;
				CHR_LF:        esc = CHR_LOW_N;
				CHR_CR:        esc = CHR_LOW_R;
				CHR_TAB:       esc = CHR_LOW_T;
				default:       esc = 8'h00;
			endcase
			if (esc != 8'h00) begin
				run_bytes[0] = CHR_BACKSLASH;
				run_bytes[1] = esc;
				n = 2;
			end else if (b < CHR_SPACE || b == CHR_DEL) begin
				run_bytes[0] = CHR_BACKSLASH;
				run_bytes[1] = CHR_LOW_U;
				run_bytes[2] = CHR_ZERO;
				run_bytes[3] = CHR_ZERO;
				run_bytes[4] = nibble_char(b[7:4]);
				run_bytes[5] = nibble_char(b[3:0]);
				n = 6;
			end else begin
				run_bytes[0] = b;
				n = 1;
			end
		end else begin
			if ((b & LEAD2_MASK) == LEAD2_TAG) begin
				seq_need = 2'd1;
			end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
				seq_need = 2'd2;
			end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
				seq_need = 2'd3;
			end else begin
				seq_need = 2'd0;
			end
			// a bad lead, or a lead that ends the string, aborts at once
			if (seq_need == 2'd0 || it.in_last) begin
				predict_abort(it.in_last);
			end else begin
				seq_bytes[0] = b;
				seq_held = 2'd1;
			end
		end
		for (k = 0; k < n; k++) begin
			r.out_byte   = run_bytes[k];
			r.run_end    = (k == n - 1);
			r.string_end = it.in_last;
			r.bad_utf8   = 1'b0;
			escaped_q.push_back(r);
		end
	endtask

	task automatic queue_byte(input logic [7:0] b, input logic last);
		in_item_t it;
		it.in_byte = b;
		it.in_last = last;
		raw_bytes_q.push_back(it);
	endtask

	function automatic logic [7:0] pick_control_byte();
		case ($urandom_range(0, 8))
			0:       return CHR_QUOTE;
			1:       return CHR_BACKSLASH;
			2:       return CHR_BS;
			3:       return CHR_FF;
			4:       return CHR_LF;
			5:       return CHR_CR;
			6:       return CHR_TAB;
			7:       return CHR_DEL;
			default: return 8'($urandom_range(0, 31));
		endcase
	endfunction

	function automatic logic [7:0] lead_byte(input int len);
		case (len)
			2:       return LEAD2_TAG | 8'($urandom_range(0, 31));
			3:       return LEAD3_TAG | 8'($urandom_range(0, 15));
			default: return LEAD4_TAG | 8'($urandom_range(0, 7));
		endcase
	endfunction

	function automatic logic [7:0] cont_byte();
		return CONT_TAG | 8'($urandom_range(0, 63));
	endfunction

	// Build one string: mostly well-formed pieces, a quarter of the strings given a break
	// piece, mostly malformed, often with random bytes after it that the block drops after an abort.
	task automatic add_random_string();
		logic [7:0] s [$];
		int         pieces;
		int         brk_at;
		int         len;
		int         p;
		int         i;
		bit         broken;
		bit         cut_short;
		pieces    = $urandom_range(1, 6);
		broken    = ($urandom_range(0, 99) < 25);
		brk_at    = broken ? $urandom_range(0, pieces - 1) : pieces;
		cut_short = 1'b0;
		for (p = 0; p < brk_at; p++) begin
			case ($urandom_range(0, 2))
				0: s.push_back(pick_control_byte());
				1: s.push_back(8'($urandom_range(CHR_SPACE, 8'h7E)));
				default: begin
					len = $urandom_range(2, 4);
					s.push_back(lead_byte(len));
					repeat (len - 1) s.push_back(cont_byte());
				end
			endcase
		end
		if (broken) begin
			len = $urandom_range(2, 4);
			case ($urandom_range(0, 3))
				0: begin
					// stray continuation or a byte that never leads
					if ($urandom_range(0, 1) != 0) begin
						s.push_back(8'($urandom_range(8'h80, 8'hBF)));
					end else begin
						s.push_back(8'($urandom_range(8'hF8, 8'hFF)));
					end
				end
				1: begin
					s.push_back(lead_byte(len));
					repeat ($urandom_range(0, len - 2)) s.push_back(cont_byte());
					if ($urandom_range(0, 1) != 0) begin
						s.push_back(8'($urandom_range(8'h00, 8'h7F)));
					end else begin
						s.push_back(8'($urandom_range(8'hC0, 8'hFF)));
					end
				end
				2: begin
					// string ends with the sequence still open
					s.push_back(lead_byte(len));
					repeat ($urandom_range(0, len - 2)) s.push_back(cont_byte());
					cut_short = 1'b1;
				end
				default: s.push_back(8'($urandom_range(0, 255)));
			endcase
		end
		if (broken && !cut_short) begin
			repeat ($urandom_range(0, 3)) s.push_back(8'($urandom_range(0, 255)));
		end
		random_live += s.size();
		for (i = 0; i < s.size(); i++) begin
			queue_byte(s[i], i == s.size() - 1);
		end
	endtask

	// Driver: offer the next raw byte once the previous request is taken, idling at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item  <= '0;
		end else if (!in_valid || in_ready) begin
			if (raw_bytes_q.size() != 0 &&
				(steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
				in_valid <= 1'b1;
				in_item  <= raw_bytes_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output side: stall at random outside the steady window.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Monitor: predict on every accepted request first, then check the accepted output byte.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_escape(in_item);
				bytes_in   <= bytes_in + 1;
				strings_in <= strings_in + in_item.in_last;
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (escaped_q.size() == 0) begin
					if (mismatches < MAX_REPORTS) begin
						$display("%0t: unexpected output byte %02h end=%b str=%b bad=%b",
							$realtime, out_item.out_byte, out_item.run_end,
							out_item.string_end, out_item.bad_utf8);
					end
					mismatches++;
				end else begin
					want = escaped_q.pop_front();
					if (out_item.out_byte !== want.out_byte ||
						out_item.run_end !== want.run_end ||
						out_item.string_end !== want.string_end ||
						out_item.bad_utf8 !== want.bad_utf8) begin
						if (mismatches < MAX_REPORTS) begin
							$display({"%0t: expected byte %02h end=%b str=%b bad=%b,",
								" got %02h end=%b str=%b bad=%b"},
								$realtime, want.out_byte, want.run_end, want.string_end,
								want.bad_utf8, out_item.out_byte, out_item.run_end,
								out_item.string_end, out_item.bad_utf8);
						end
						mismatches++;
					end
				end
			end
			// Watchdog: count cycles with no request taken on either side.
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog expired with %0d escaped bytes outstanding",
					escaped_q.size());
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		int failures;

		// Escapes: control bytes, DEL, space, quote, backslash and the short escapes.
		queue_byte(8'h00, 1'b0);
		queue_byte(CHR_DEL, 1'b0);
		queue_byte(CHR_SPACE, 1'b0);
		queue_byte(CHR_QUOTE, 1'b0);
		queue_byte(CHR_BACKSLASH, 1'b0);
		queue_byte(CHR_BS, 1'b0);
		queue_byte(CHR_FF, 1'b0);
		queue_byte(CHR_LF, 1'b0);
		queue_byte(CHR_CR, 1'b0);
		queue_byte(CHR_TAB, 1'b1);
		// Well-formed two-, three- and four-byte sequences, string ends on the last one.
		queue_byte(8'hC3, 1'b0);
		queue_byte(8'hA9, 1'b0);
		queue_byte(8'hE2, 1'b0);
		queue_byte(8'h82, 1'b0);
		queue_byte(8'hAC, 1'b0);
		queue_byte(8'hF0, 1'b0);
		queue_byte(8'h9F, 1'b0);
		queue_byte(8'h98, 1'b0);
		queue_byte(8'h80, 1'b1);
		// Bad lead byte mid-string; the rest of the string is dropped.
		queue_byte(8'hF8, 1'b0);
		queue_byte(8'h41, 1'b1);
		// Bad continuation, then a dropped final byte.
		queue_byte(8'hC3, 1'b0);
		queue_byte(8'h41, 1'b0);
		queue_byte(8'hFF, 1'b1);
		// String ends inside a sequence: on a continuation, then on a lead.
		queue_byte(8'hE2, 1'b0);
		queue_byte(8'h82, 1'b1);
		queue_byte(8'hF0, 1'b1);
		// Bad lead byte as the last byte of a string.
		queue_byte(8'h80, 1'b1);

		while (random_live < RANDOM_BYTES) begin
			add_random_string();
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Wait for every request to go in, every predicted byte to come out, then drain.
		while (raw_bytes_q.size() != 0 || in_valid) @(negedge clk);
		while (escaped_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		failures = mismatches + escaped_q.size();
		$display("Sent %0d raw bytes in %0d strings; checked %0d escaped bytes, %0d UTF-8 aborts",
			bytes_in, strings_in, results_seen, error_reports);
		$display("Mismatched or unexpected bytes: %0d, still owed: %0d",
			mismatches, escaped_q.size());
		if (failures == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/jsesc_pkg.sv
rtl/jsesc_front.sv
rtl/jsesc_fifo.sv
rtl/jsesc_back.sv
rtl/json_string_escaper_utf8_check.sv
sim/tb_json_string_escaper_utf8_check.sv
